// ===== rtl/lzfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lzfp_pkg
// shared types, constants and code decoding for the flag-pair lz decoder
// ----------------------------------------------------------------------------
package lzfp_pkg;

   localparam int WINDOW_DEPTH = 2048;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int COUNT_WIDTH  = 24;
   localparam int TOTAL_W      = 24;
   localparam int LEN_W        = 6;

   localparam logic [LEN_W-1:0]  MATCH_LEN_BIAS = LEN_W'(4);
   localparam logic [ADDR_W:0]   DIST_BIAS      = (ADDR_W + 1)'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [1:0] CODE_SKIP  = 2'd0;
   localparam logic [1:0] CODE_LIT   = 2'd1;
   localparam logic [1:0] CODE_MATCH = 2'd2;
   localparam logic [1:0] CODE_RUN   = 2'd3;

   localparam logic [1:0] LAST_INDEX = 2'd3;

   typedef logic [ADDR_W-1:0] ptr_type;
   typedef logic [ADDR_W:0]   dist_type;

   typedef enum logic [3:0] {
      PH_FLAG,
      PH_LIT,
      PH_MHI,
      PH_MLO,
      PH_SKIPCNT,
      PH_SKIP,
      PH_RUNCNT,
      PH_RUN,
      PH_COPY
   } phase_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
      logic [7:0] data;
   } hist_wr_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
   } hist_rd_type;

   function automatic phase_type code_phase(input logic [1:0] code);
      phase_type p;
      unique case (code)
         CODE_SKIP:  p = PH_SKIPCNT;
         CODE_LIT:   p = PH_LIT;
         CODE_MATCH: p = PH_MHI;
         CODE_RUN:   p = PH_RUNCNT;
         default:    p = PH_RUNCNT;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/lzfp_history.sv =====
// ----------------------------------------------------------------------------
// lzfp_history
// history window ram, one write and one registered read port, write-first
// ----------------------------------------------------------------------------
module lzfp_history (
   input  logic                 clock,
   input  lzfp_pkg::hist_wr_type wr,
   input  lzfp_pkg::hist_rd_type rd,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [lzfp_pkg::WINDOW_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // same-entry read and write forwards the new byte
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lz_flag_pair_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz_flag_pair_decompressor
// lz77 stream decoder with four 2-bit codes per flag byte and a 2048-byte
// history window
// ----------------------------------------------------------------------------
// a literal or run byte shows on rsp in the cycle after it is taken
// throughput: one input item per cycle outside matches while rsp is not stalled
// a match copies 4 to 35 bytes after its second byte, one history byte per cycle
//   through the single ram read port while rsp is not stalled; no input is taken meanwhile
// reset clears the parser, counters and output valid flag; the history ram is
//   not cleared, reads are gated by the stream byte count
// ----------------------------------------------------------------------------
module lz_flag_pair_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // stream_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_byte [7:0], total_written [31:8]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // has_data [0], end_of_stream [1]
);

   lzfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  flag_bits_ff, flag_bits_in;
   logic [1:0]  flag_index_ff, flag_index_in;
   logic [7:0]  match_hi_ff, match_hi_in;
   logic [7:0]  run_ff, run_in;
   lzfp_pkg::ptr_type  wp_ff, wp_in;
   lzfp_pkg::dist_type dist_ff, dist_in;
   logic [lzfp_pkg::LEN_W-1:0] copy_rem_ff, copy_rem_in;
   logic [lzfp_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic        ended_ff, ended_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_has_ff, rsp_last_ff, rsp_end_ff;
   logic [lzfp_pkg::TOTAL_W-1:0] rsp_total_ff;

   logic        slot_free, req_fire, item_live;
   logic        emit, emit_has, emit_last, emit_end;
   logic [7:0]  emit_byte;
   lzfp_pkg::hist_wr_type hist_wr;
   lzfp_pkg::hist_rd_type hist_rd;
   logic [7:0]  hist_data;

   lzfp_pkg::dist_type     new_dist;
   logic [lzfp_pkg::LEN_W-1:0] new_len;
   lzfp_pkg::phase_type    adv_phase;
   logic [1:0]  adv_index, next_index;
   logic [7:0]  run_dec;

   lzfp_history u_history (
      .clock   (clock),
      .wr      (hist_wr),
      .rd      (hist_rd),
      .rd_data (hist_data)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (phase_ff != lzfp_pkg::PH_COPY) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign item_live  = req_fire && !req_tuser && !ended_ff;

   assign new_dist = {1'b0, match_hi_ff, req_tdata[7:5]} + lzfp_pkg::DIST_BIAS;
   assign new_len  = {1'b0, req_tdata[4:0]} + lzfp_pkg::MATCH_LEN_BIAS;
   assign run_dec  = run_ff - 8'd1;

   // step to the next code of the current flag byte, or back to a new flag byte after the last
   assign next_index = flag_index_ff + 2'd1;
   always_comb begin
      if (flag_index_ff == lzfp_pkg::LAST_INDEX) begin
         adv_phase = lzfp_pkg::PH_FLAG;
         adv_index = 2'd0;
      end else begin
         adv_phase = lzfp_pkg::code_phase(flag_bits_ff[{next_index, 1'b0} +: 2]);
         adv_index = next_index;
      end
   end

   // outputs: results, history writes and reads
   always_comb begin
      emit       = 1'b0;
      emit_byte  = 8'd0;
      emit_has   = 1'b0;
      emit_last  = 1'b0;
      emit_end   = 1'b0;
      hist_wr.en   = 1'b0;
      hist_wr.addr = wp_ff;
      hist_rd.en   = 1'b0;
      hist_rd.addr = wp_ff - new_dist[lzfp_pkg::ADDR_W-1:0];
      if (item_live) begin
         unique case (phase_ff)
            lzfp_pkg::PH_FLAG: begin
               if (req_tdata == 8'd0) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_end  = 1'b1;
               end
            end
            lzfp_pkg::PH_LIT, lzfp_pkg::PH_RUN: begin
               emit       = 1'b1;
               emit_byte  = req_tdata;
               emit_has   = 1'b1;
               emit_last  = 1'b1;
               hist_wr.en = 1'b1;
            end
            lzfp_pkg::PH_MLO: begin
               hist_rd.en = 1'b1;
            end
            default: begin
            end
         endcase
      end else if ((phase_ff == lzfp_pkg::PH_COPY) && slot_free) begin
         emit       = 1'b1;
         emit_byte  = (count_ff >= lzfp_pkg::COUNT_WIDTH'(dist_ff)) ? hist_data : 8'd0;
         emit_has   = 1'b1;
         emit_last  = (copy_rem_ff == lzfp_pkg::LEN_W'(1));
         hist_wr.en = 1'b1;
         hist_rd.en = (copy_rem_ff != lzfp_pkg::LEN_W'(1));
         hist_rd.addr = wp_ff + lzfp_pkg::ADDR_W'(1) - dist_ff[lzfp_pkg::ADDR_W-1:0];
      end
      hist_wr.data = emit_byte;
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      flag_bits_in  = flag_bits_ff;
      flag_index_in = flag_index_ff;
      match_hi_in   = match_hi_ff;
      run_in        = run_ff;
      wp_in         = wp_ff;
      dist_in       = dist_ff;
      copy_rem_in   = copy_rem_ff;
      count_in      = count_ff;
      ended_in      = ended_ff;

      if (hist_wr.en) begin
         wp_in = wp_ff + lzfp_pkg::ADDR_W'(1);
         if (count_ff != lzfp_pkg::COUNT_MAX) begin
            count_in = count_ff + lzfp_pkg::COUNT_WIDTH'(1);
         end
      end

      if (req_fire && req_tuser) begin
         count_in      = '0;
         wp_in         = '0;
         ended_in      = 1'b0;
         flag_bits_in  = req_tdata;
         flag_index_in = 2'd0;
         phase_in      = lzfp_pkg::code_phase(req_tdata[1:0]);
      end else if (item_live) begin
         unique case (phase_ff)
            lzfp_pkg::PH_FLAG: begin
               if (req_tdata == 8'd0) begin
                  ended_in = 1'b1;
               end else begin
                  flag_bits_in  = req_tdata;
                  flag_index_in = 2'd0;
                  phase_in      = lzfp_pkg::code_phase(req_tdata[1:0]);
               end
            end
            lzfp_pkg::PH_LIT: begin
               phase_in      = adv_phase;
               flag_index_in = adv_index;
            end
            lzfp_pkg::PH_MHI: begin
               match_hi_in = req_tdata;
               phase_in    = lzfp_pkg::PH_MLO;
            end
            lzfp_pkg::PH_MLO: begin
               dist_in     = new_dist;
               copy_rem_in = new_len;
               phase_in    = lzfp_pkg::PH_COPY;
            end
            lzfp_pkg::PH_SKIPCNT: begin
               run_in = req_tdata;
               if (req_tdata == 8'd0) begin
                  flag_index_in = 2'd0;
                  phase_in      = lzfp_pkg::PH_FLAG;
               end else begin
                  phase_in = lzfp_pkg::PH_SKIP;
               end
            end
            lzfp_pkg::PH_SKIP: begin
               run_in = run_dec;
               if (run_dec == 8'd0) begin
                  flag_index_in = 2'd0;
                  phase_in      = lzfp_pkg::PH_FLAG;
               end
            end
            lzfp_pkg::PH_RUNCNT: begin
               run_in = req_tdata;
               if (req_tdata == 8'd0) begin
                  phase_in      = adv_phase;
                  flag_index_in = adv_index;
               end else begin
                  phase_in = lzfp_pkg::PH_RUN;
               end
            end
            lzfp_pkg::PH_RUN: begin
               run_in = run_dec;
               if (run_dec == 8'd0) begin
                  phase_in      = adv_phase;
                  flag_index_in = adv_index;
               end
            end
            default: begin
            end
         endcase
      end else if ((phase_ff == lzfp_pkg::PH_COPY) && emit) begin
         copy_rem_in = copy_rem_ff - lzfp_pkg::LEN_W'(1);
         if (emit_last) begin
            phase_in      = adv_phase;
            flag_index_in = adv_index;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lzfp_pkg::PH_FLAG;
         flag_bits_ff  <= '0;
         flag_index_ff <= '0;
         match_hi_ff   <= '0;
         run_ff        <= '0;
         wp_ff         <= '0;
         dist_ff       <= '0;
         copy_rem_ff   <= '0;
         count_ff      <= '0;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flag_index_ff <= flag_index_in;
         match_hi_ff   <= match_hi_in;
         run_ff        <= run_in;
         wp_ff         <= wp_in;
         dist_ff       <= dist_in;
         copy_rem_ff   <= copy_rem_in;
         count_ff      <= count_in;
         ended_ff      <= ended_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff  <= emit_byte;
         rsp_has_ff   <= emit_has;
         rsp_last_ff  <= emit_last;
         rsp_end_ff   <= emit_end;
         rsp_total_ff <= lzfp_pkg::TOTAL_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_end_ff, rsp_has_ff};

   a_emit_slot_free : assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("item produced while output register is occupied");

   a_copy_rem_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lzfp_pkg::PH_COPY) |-> (copy_rem_ff != '0))
      else $error("match copy with no bytes left");

   a_copy_leaves : assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == lzfp_pkg::PH_COPY) && emit && emit_last)
         |=> (phase_ff != lzfp_pkg::PH_COPY))
      else $error("match copy did not finish on its last byte");

   a_ended_quiet : assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> !hist_wr.en)
      else $error("history written after end of stream");

endmodule
